### rtl/binary_disk_dilate_erode_assert.svh
// Assertion macros shared by the design files. The enclosing module must
// provide clk and rst; checks are disabled while rst is high.
`ifndef BINARY_DISK_DILATE_ERODE_ASSERT_SVH
`define BINARY_DISK_DILATE_ERODE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bdde_pkg.sv
package bdde_pkg;

  localparam int MAX_COLS   = 2048;
  localparam int MAX_RADIUS = 7;

  // The window is square, with sides of twice the largest radius plus one.
  // The line memory keeps the rows above the newest one.
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int HIST   = WIN - 1;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ECOL_W = $clog2(MAX_COLS + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int ROW_W  = 16;
  localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_COLS + MAX_RADIUS + 1);

  localparam int OPER_W  = 1;
  localparam int RADF_W  = 3;
  localparam int NCOLS_W = 12;
  localparam int NROWS_W = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = CFG_IDX_W'(3);

  localparam logic [RADF_W-1:0]  RST_RADIUS   = RADF_W'(1);
  localparam logic [NCOLS_W-1:0] RST_NUM_COLS = NCOLS_W'(2048);
  localparam logic [NROWS_W-1:0] RST_NUM_ROWS = NROWS_W'(1024);

  localparam logic OP_DILATE  = 1'b0;
  localparam logic OP_ERODE   = 1'b1;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic mode;
    logic pixel_in;
  } in_word_t;

  typedef struct packed {
    logic pixel_out;
    logic row_end;
    logic frame_end;
  } out_word_t;

  typedef logic [WIN-1:0]  col_t;
  typedef logic [HIST-1:0] hist_t;

  // Window indexed [column][row]; column 0 and row 0 are the newest.
  typedef logic [WIN-1:0][WIN-1:0] win_t;
  typedef logic [MAX_RADIUS:0][WIN-1:0][WIN-1:0] disk_tbl_t;

  typedef struct packed {
    logic             operation;
    logic [RAD_W-1:0] rad;
  } cfg_t;

  // Per-word control carried from the position counters to the window.
  typedef struct packed {
    logic             emit;
    logic             row_end;
    logic             frame_end;
    logic [COL_W-1:0] addr;
    col_t             row_ok;
    col_t             col_ok;
  } tag_t;

  // Disk shape for every radius: column k and row b sit at offsets
  // radius - k and radius - b from the center.
  function automatic disk_tbl_t build_disk_tbl();
    disk_tbl_t tbl;
    int        di;
    int        dj;
    tbl = '0;
    for (int r = 0; r <= MAX_RADIUS; r++) begin
      for (int k = 0; k < WIN; k++) begin
        for (int b = 0; b < WIN; b++) begin
          dj = r - k;
          di = r - b;
          tbl[r][k][b] = (di * di + dj * dj <= r * r);
        end
      end
    end
    return tbl;
  endfunction

  localparam disk_tbl_t DISK_TBL = build_disk_tbl();

endpackage

### rtl/binary_disk_dilate_erode.sv
// A word accepted passes two register stages, the window stage and the output register,
// before its result, if any, shows on out_word; out_stall can hold it in the window stage.
// Throughput: one word per cycle while not stalled; one line memory read and write per word.
// A frame of R rows and C columns takes R*C + radius*C + radius words, drain words included.
// Reset (rst, synchronous) empties the pipeline, zeroes all position counters and restores
// the register defaults; the line memory is not cleared and needs no clearing pass.
`include "binary_disk_dilate_erode_assert.svh"

module binary_disk_dilate_erode (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bdde_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bdde_pkg::out_word_t               out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdde_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bdde_pkg::*;

  // Pipeline overview.
  // The position unit counts accepted words. It keeps the input column, which
  // addresses the line memory, and the output row and column, which lag the
  // input by radius rows plus radius pixels. For each word it also works out
  // which window rows and columns fall inside the frame.
  // The line memory holds, for every image column, the pixels of the rows
  // above the current one. The read is registered as the word is accepted;
  // the window stage then stacks the new pixel on that history, writes
  // the newest rows back and shifts the column into a square window register.
  // The output pixel is the OR (dilate) or AND (erode) of the window pixels
  // that lie in the disk and inside the frame; it goes to the output register.
  // Because the window stage can hold one word while a result waits in the
  // output register, a new word is still taken while the output is stalled.

  logic  accept;
  logic  cfg_write;
  cfg_t  cfg;
  tag_t  tag;
  logic  wr_en;
  logic  [COL_W-1:0] wr_addr;
  hist_t wr_data;
  hist_t rd_data;

  // Registers are always writable; writes are expected only while idle.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  bdde_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cfg       (cfg),
    .tag       (tag)
  );

  // Line memory: one entry per column, one bit per stored row.
  bdde_ram #(
    .WIDTH (HIST),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (tag.addr),
    .rd_data (rd_data)
  );

  bdde_win u_win (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .tag       (tag),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### rtl/bdde_ram.sv
module bdde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bdde_pos.sv
`include "binary_disk_dilate_erode_assert.svh"

module bdde_pos (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bdde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdde_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                accept,
  output bdde_pkg::cfg_t                      cfg,
  output bdde_pkg::tag_t                      tag
);

  import bdde_pkg::*;

  logic               operation;
  logic [RADF_W-1:0]  radius;
  logic [NCOLS_W-1:0] num_cols;
  logic [NROWS_W-1:0] num_rows;

  logic [ECOL_W-1:0]  cols;
  logic [ROW_W-1:0]   rows;
  logic [RAD_W-1:0]   rad;
  logic [LAG_W-1:0]   lag;
  logic               cfg_hit;

  logic [COL_W-1:0]   in_col;
  logic [LAG_W-1:0]   fill;
  logic [COL_W-1:0]   ocol;
  logic [ROW_W-1:0]   orow;
  logic [COL_W-1:0]   in_col_next;
  logic [LAG_W-1:0]   fill_next;
  logic [COL_W-1:0]   ocol_next;
  logic [ROW_W-1:0]   orow_next;

  logic               in_wrap;
  logic               emit;
  logic               row_end;
  logic               last_row;
  logic               frame_end;
  logic [ROW_W+1:0]   row_sum;
  logic [ECOL_W+1:0]  col_sum;
  col_t               row_ok;
  col_t               col_ok;

  // Effective sizes: zero rows or columns become one; columns and radius clamp.
  always_comb begin
    priority if (num_cols == '0) begin
      cols = ECOL_W'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols = ECOL_W'(MAX_COLS);
    end else begin
      cols = ECOL_W'(num_cols);
    end
    rows = (num_rows == '0) ? ROW_W'(1) : num_rows;
    if (int'(radius) > MAX_RADIUS) begin
      rad = RAD_W'(MAX_RADIUS);
    end else begin
      rad = RAD_W'(radius);
    end
  end

  // Words to take in before the first result: radius rows plus radius pixels.
  assign lag = LAG_W'(rad) * LAG_W'(cols) + LAG_W'(rad);

  assign cfg_hit = cfg_write && (cfg_index == CFG_OPERATION || cfg_index == CFG_RADIUS ||
                                 cfg_index == CFG_NUM_COLS || cfg_index == CFG_NUM_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_DILATE;
      radius    <= RST_RADIUS;
      num_cols  <= RST_NUM_COLS;
      num_rows  <= RST_NUM_ROWS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_OPERATION: operation <= cfg_data[OPER_W-1:0];
        CFG_RADIUS:    radius    <= cfg_data[RADF_W-1:0];
        CFG_NUM_COLS:  num_cols  <= cfg_data[NCOLS_W-1:0];
        CFG_NUM_ROWS:  num_rows  <= cfg_data[NROWS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_wrap   = (ECOL_W'(in_col) + ECOL_W'(1)) >= cols;
  assign emit      = (fill == lag);
  assign row_end   = (ECOL_W'(ocol) + ECOL_W'(1)) >= cols;
  assign last_row  = ((ROW_W+1)'(orow) + (ROW_W+1)'(1)) >= (ROW_W+1)'(rows);
  assign frame_end = row_end && last_row;

  always_comb begin
    in_col_next = in_wrap ? '0 : in_col + 1'b1;
    fill_next   = fill;
    ocol_next   = ocol;
    orow_next   = orow;
    priority if (!emit) begin
      fill_next = fill + 1'b1;
    end else if (frame_end) begin
      in_col_next = '0;
      fill_next   = '0;
      ocol_next   = '0;
      orow_next   = '0;
    end else if (row_end) begin
      ocol_next = '0;
      orow_next = orow + 1'b1;
    end else begin
      ocol_next = ocol + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_col <= '0;
      fill   <= '0;
      ocol   <= '0;
      orow   <= '0;
    end else if (accept) begin
      in_col <= in_col_next;
      fill   <= fill_next;
      ocol   <= ocol_next;
      orow   <= orow_next;
    end
  end

  // Window row b holds image row orow + rad - b, column k holds ocol + rad - k.
  assign row_sum = (ROW_W+2)'(orow) + (ROW_W+2)'(rad);
  assign col_sum = (ECOL_W+2)'(ocol) + (ECOL_W+2)'(rad);

  for (genvar i = 0; i < WIN; i++) begin : g_bounds
    assign row_ok[i] = (row_sum >= (ROW_W+2)'(i)) &&
                       (row_sum < (ROW_W+2)'(rows) + (ROW_W+2)'(i));
    assign col_ok[i] = (col_sum >= (ECOL_W+2)'(i)) &&
                       (col_sum < (ECOL_W+2)'(cols) + (ECOL_W+2)'(i));
  end

  assign cfg.operation = operation;
  assign cfg.rad       = rad;

  assign tag.emit      = emit;
  assign tag.row_end   = row_end;
  assign tag.frame_end = frame_end;
  assign tag.addr      = in_col;
  assign tag.row_ok    = row_ok;
  assign tag.col_ok    = col_ok;

  `BDDE_ASSERT_NOW(a_fill_bounded, 1'b1, fill <= lag, "fill count passed the lag")
  `BDDE_ASSERT_NOW(a_cols_bounded, 1'b1,
    (ECOL_W'(ocol) < cols) && (ECOL_W'(in_col) < cols), "column counter out of row")

endmodule

### rtl/bdde_win.sv
`include "binary_disk_dilate_erode_assert.svh"

module bdde_win (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  output logic                          in_stall,
  input  bdde_pkg::in_word_t            in_word,
  input  bdde_pkg::tag_t                tag,
  input  bdde_pkg::cfg_t                cfg,
  input  bdde_pkg::hist_t               rd_data,
  output logic                          wr_en,
  output logic [bdde_pkg::COL_W-1:0]    wr_addr,
  output bdde_pkg::hist_t               wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bdde_pkg::out_word_t           out_word
);

  import bdde_pkg::*;

  logic  s1_valid;
  tag_t  s1_tag;
  logic  s1_px;
  logic  s1_fire;
  logic  byp_hit;
  hist_t byp_data;
  hist_t hist;
  col_t  col_new;
  win_t  win;
  win_t  win_next;
  win_t  disk;
  win_t  mask;
  logic  hit1;
  logic  hit0;
  logic  pixel;

  // The stage moves on unless it holds a result while a full output is stalled.
  assign s1_fire  = s1_valid && (!s1_tag.emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;

  // With one-pixel rows the word just accepted reads the column being written.
  assign hist    = byp_hit ? byp_data : rd_data;
  assign col_new = {hist, s1_px};

  assign wr_en   = s1_fire;
  assign wr_addr = s1_tag.addr;
  assign wr_data = col_new[HIST-1:0];

  assign win_next = {win[WIN-2:0], col_new};
  assign disk     = DISK_TBL[cfg.rad];

  for (genvar k = 0; k < WIN; k++) begin : g_mask
    assign mask[k] = disk[k] & s1_tag.row_ok & {WIN{s1_tag.col_ok[k]}};
  end

  assign hit1  = |(win_next & mask);
  assign hit0  = |(~win_next & mask);
  assign pixel = (cfg.operation == OP_ERODE) ? !hit0 : hit1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1_tag.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag   <= tag;
      s1_px    <= (in_word.mode == MODE_PIXEL) && in_word.pixel_in;
      byp_hit  <= s1_fire && (tag.addr == s1_tag.addr);
      byp_data <= col_new[HIST-1:0];
    end
    if (s1_fire) begin
      win <= win_next;
    end
    if (s1_fire && s1_tag.emit) begin
      out_word.pixel_out <= pixel;
      out_word.row_end   <= s1_tag.row_end;
      out_word.frame_end <= s1_tag.frame_end;
    end
  end

  `BDDE_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_fire,
    s1_valid && $stable(s1_tag), "held stage lost its word")
  `BDDE_ASSERT_NOW(a_out_source, $rose(out_valid),
    $past(s1_valid && s1_tag.emit), "result without an emitting word")

endmodule
